FILE: design/pce_pkg.sv
// Package for the Pearson correlation engine: field widths, sequencer
// states and the request and response bundles of the serial multiplier.
// Depends on nothing.
`default_nettype none
package pce_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 47;
    localparam int XY_W     = 48;
    localparam int WIDE_W   = 64;
    localparam int PROD_W   = 128;
    localparam int QUO_W    = 31;
    localparam int ROOT_W   = 16;
    localparam int SMUL_W   = 17;

    localparam logic signed [SAMPLE_W-1:0] CORR_ONE = 16'sd32767;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACC    = 7'b0000010,
        S_MSTART = 7'b0000100,
        S_MWAIT  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_ROOT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [WIDE_W-1:0] a;
        logic signed [WIDE_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] product;
    } t_mul_rsp;

endpackage
`default_nettype wire

FILE: design/pce_serial_mul.sv
// Shift-and-add signed multiplier, 64 by 64 bits, one partial product a cycle.
// Depends on pce_pkg for widths and the request and response bundles.
`default_nettype none
module pce_serial_mul
    import pce_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam int CNT_W = $clog2(WIDE_W);

    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mc;
    logic [WIDE_W-1:0] r_mp;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [WIDE_W-1:0] mag_a;
    logic [WIDE_W-1:0] mag_b;

    assign mag_a = i_req.a[WIDE_W-1] ? WIDE_W'(-i_req.a) : WIDE_W'(i_req.a);
    assign mag_b = i_req.b[WIDE_W-1] ? WIDE_W'(-i_req.b) : WIDE_W'(i_req.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(WIDE_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_mc  <= PROD_W'(mag_a);
            r_mp  <= mag_b;
            r_neg <= i_req.a[WIDE_W-1] ^ i_req.b[WIDE_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc  <= r_mc << 1;
            r_mp  <= r_mp >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_neg ? $signed(-r_acc) : $signed(r_acc);

endmodule
`default_nettype wire

FILE: design/pearson_correlation_engine_core.sv
// Pearson correlation engine, top level: pair accumulation, final sequencer,
// division and square root.  Depends on pce_pkg and pce_serial_mul.
//
// A pair that is not the last is accepted in S_IDLE, which adds the sums;
// then one shared 17 by 17 multiplier forms x*x, y*y and x*y in turn in
// S_ACC. A dropped pair is not summed and sets the drop flag. The last pair
// adds the final pass: eight products on the serial 64 by 64 multiplier,
// 31 restoring division steps, 16 square root steps on the small multiplier
// and the S_OUT state, which loads the output once its register is free.
// A zero numerator, as from a constant vector, skips the last two products,
// the division and the root search. The input is not ready while an item is
// at work; it is ready again while the result beat waits to be taken.
`default_nettype none
module pearson_correlation_engine_core
    import pce_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_x_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_y_sample,
    input  wire logic                       i_last_pair,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0]      o_correlation,
    output logic                            o_degenerate,
    output logic                            o_overflowed
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    t_state r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;
    logic [SQ_W-1:0]          r_sxx;
    logic [SQ_W-1:0]          r_syy;
    logic signed [XY_W-1:0]   r_sxy;
    logic                     r_drop;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                     r_last;
    logic [1:0]               r_phase;
    logic [2:0]               r_job;
    logic signed [WIDE_W-1:0] r_t1;
    logic signed [WIDE_W-1:0] r_num;
    logic signed [WIDE_W-1:0] r_dx;
    logic signed [WIDE_W-1:0] r_dy;
    logic [PROD_W-1:0]        r_p;
    logic [PROD_W:0]          r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic [4:0]               r_step;
    logic [ROOT_W-1:0]        r_root;
    logic [3:0]               r_bit;
    logic signed [SAMPLE_W-1:0] r_res_corr;
    logic                     r_res_degen;
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_corr;
    logic                     r_out_degen;
    logic                     r_out_ovf;

    logic                       in_accept;
    logic                       room;
    logic [SAMPLE_BITS-1:0]     x_raw;
    logic [SAMPLE_BITS-1:0]     y_raw;
    logic signed [SAMPLE_W-1:0] x_ext;
    logic signed [SAMPLE_W-1:0] y_ext;
    logic signed [SMUL_W-1:0]   sm_a;
    logic signed [SMUL_W-1:0]   sm_b;
    logic signed [2*SMUL_W-1:0] sm_p;
    logic [ROOT_W-1:0]          trial;
    t_mul_req                   mreq;
    t_mul_rsp                   mrsp;
    logic signed [WIDE_W-1:0]   diff;
    logic [PROD_W:0]            rem_sh;
    logic                       out_free;

    assign x_raw = i_x_sample[SAMPLE_BITS-1:0];
    assign y_raw = i_y_sample[SAMPLE_BITS-1:0];
    assign x_ext = SAMPLE_W'($signed(x_raw));
    assign y_ext = SAMPLE_W'($signed(y_raw));

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign room       = (r_cnt < CNT_W'(MAX_SAMPLES));
    assign out_free   = !r_out_valid || i_out_ready;

    // Shared small multiplier: squares and cross product while accumulating,
    // trial squares during the root search.
    assign trial = r_root | (ROOT_W'(1) << r_bit);
    always_comb begin
        sm_a = {1'b0, trial};
        sm_b = {1'b0, trial};
        if (r_state == S_ACC) begin
            case (r_phase)
                2'd0: begin
                    sm_a = SMUL_W'(r_x);
                    sm_b = SMUL_W'(r_x);
                end
                2'd1: begin
                    sm_a = SMUL_W'(r_y);
                    sm_b = SMUL_W'(r_y);
                end
                default: begin
                    sm_a = SMUL_W'(r_x);
                    sm_b = SMUL_W'(r_y);
                end
            endcase
        end
    end
    assign sm_p = sm_a * sm_b;

    always_comb begin
        mreq.start = (r_state == S_MSTART);
        case (r_job)
            3'd0: begin
                mreq.a = WIDE_W'(r_cnt);
                mreq.b = WIDE_W'(r_sxy);
            end
            3'd1: begin
                mreq.a = WIDE_W'(r_sx);
                mreq.b = WIDE_W'(r_sy);
            end
            3'd2: begin
                mreq.a = WIDE_W'(r_cnt);
                mreq.b = WIDE_W'(r_sxx);
            end
            3'd3: begin
                mreq.a = WIDE_W'(r_sx);
                mreq.b = WIDE_W'(r_sx);
            end
            3'd4: begin
                mreq.a = WIDE_W'(r_cnt);
                mreq.b = WIDE_W'(r_syy);
            end
            3'd5: begin
                mreq.a = WIDE_W'(r_sy);
                mreq.b = WIDE_W'(r_sy);
            end
            3'd6: begin
                mreq.a = r_dx;
                mreq.b = r_dy;
            end
            default: begin
                mreq.a = r_num;
                mreq.b = r_num;
            end
        endcase
    end

    pce_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    assign diff   = r_t1 - WIDE_W'(mrsp.product);
    assign rem_sh = (r_step == 5'd0) ? r_rem : (r_rem << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_syy       <= '0;
            r_sxy       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loaded in S_OUT takes the place of the one taken.
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_x     <= x_ext;
                        r_y     <= y_ext;
                        r_last  <= i_last_pair;
                        r_phase <= 2'd0;
                        r_job   <= 3'd0;
                        if (room) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_sx    <= r_sx + SUM_W'(x_ext);
                            r_sy    <= r_sy + SUM_W'(y_ext);
                            r_state <= S_ACC;
                        end else begin
                            r_drop <= 1'b1;
                            if (i_last_pair) begin
                                r_state <= S_MSTART;
                            end
                        end
                    end
                end
                S_ACC: begin
                    case (r_phase)
                        2'd0: r_sxx <= r_sxx + SQ_W'(sm_p);
                        2'd1: r_syy <= r_syy + SQ_W'(sm_p);
                        default: r_sxy <= r_sxy + XY_W'(sm_p);
                    endcase
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == 2'd2) begin
                        r_state <= r_last ? S_MSTART : S_IDLE;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mrsp.done) begin
                        case (r_job)
                            3'd1: r_num <= diff;
                            3'd3: r_dx  <= diff[WIDE_W-1] ? '0 : diff;
                            3'd5: r_dy  <= diff[WIDE_W-1] ? '0 : diff;
                            3'd6: r_p   <= PROD_W'(mrsp.product);
                            3'd7: r_rem <= (PROD_W + 1)'(mrsp.product);
                            default: r_t1 <= WIDE_W'(mrsp.product);
                        endcase
                        r_job <= r_job + 1'b1;
                        if ((r_job == 3'd5) && (r_num == '0)) begin
                            // Zero numerator: forced to +1.0 and flagged.
                            r_res_corr  <= CORR_ONE;
                            r_res_degen <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (r_job == 3'd7) begin
                            r_step  <= 5'd0;
                            r_quo   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_DIV: begin
                    // The first step is unshifted: num squared never exceeds the
                    // denominator product, so the top quotient bit is at 2^30.
                    if (rem_sh >= {1'b0, r_p}) begin
                        r_rem <= rem_sh - {1'b0, r_p};
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'(QUO_W - 1)) begin
                        r_root  <= '0;
                        r_bit   <= 4'(ROOT_W - 1);
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    logic [ROOT_W-1:0] root_n;
                    root_n = r_root;
                    if ($unsigned(sm_p) <= (2*SMUL_W)'(r_quo)) begin
                        root_n = trial;
                    end
                    r_root <= root_n;
                    r_bit  <= r_bit - 1'b1;
                    if (r_bit == 4'd0) begin
                        r_res_degen <= 1'b0;
                        if (r_num[WIDE_W-1]) begin
                            r_res_corr <= SAMPLE_W'(-$signed({1'b0, root_n}));
                        end else if (root_n[ROOT_W-1]) begin
                            r_res_corr <= CORR_ONE;
                        end else begin
                            r_res_corr <= $signed(root_n);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_corr  <= r_res_corr;
                        r_out_degen <= r_res_degen;
                        r_out_ovf   <= r_drop;
                        r_cnt       <= '0;
                        r_sx        <= '0;
                        r_sy        <= '0;
                        r_sxx       <= '0;
                        r_syy       <= '0;
                        r_sxy       <= '0;
                        r_drop      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_correlation = r_out_corr;
    assign o_degenerate  = r_out_degen;
    assign o_overflowed  = r_out_ovf;

    a_degen_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_correlation == CORR_ONE)
        else $error("degenerate result not forced to +1.0");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SAMPLES))
        else $error("pair count beyond capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_last_pair && room |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("pair count did not advance");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT |-> r_quo <= QUO_W'(31'h4000_0000))
        else $error("quotient above one");

endmodule
`default_nettype wire
